// ===== rtl/bli_pkg.sv =====
// bli_pkg: shared types and constants of the bracket language interpreter
// command and status codes, instruction characters, controller states, control structs
// no dependencies
`default_nettype none

package bli_pkg;

	localparam int unsigned PROG_DEPTH_DEF  = 256;
	localparam int unsigned DATA_DEPTH_DEF  = 256;
	localparam int unsigned STACK_DEPTH_DEF = 255;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_EXEC  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_WAIT      = 3'd1,
		ST_END       = 3'd2,
		ST_INVALID   = 3'd3,
		ST_OVER      = 3'd4,
		ST_UNDER     = 3'd5,
		ST_UNMATCHED = 3'd6
	} status_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
	localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]
	localparam logic [7:0] CH_RIGHT = 8'h3E;  // >
	localparam logic [7:0] CH_LEFT  = 8'h3C;  // <
	localparam logic [7:0] CH_INC   = 8'h2B;  // +
	localparam logic [7:0] CH_DEC   = 8'h2D;  // -
	localparam logic [7:0] CH_OUT   = 8'h2E;  // .
	localparam logic [7:0] CH_IN    = 8'h2C;  // ,

	typedef enum logic [2:0] {
		S_IDLE,
		S_REPLY,
		S_EXEC,
		S_SCAN_RD,
		S_SCAN_CHK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;      // latch word, issue fetch, cell and stack reads
		logic reply;       // load, start, none or halted step: finish and emit
		logic exec;        // commit one instruction and emit
		logic scan_start;  // begin forward bracket scan
		logic scan_rd;     // read program entry at scan address
		logic scan_step;   // advance scan past current entry
		logic scan_end;    // finish scan and emit
		logic scan_hit;    // scan found the matching close
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_exec;    // offered word is an execute on a running machine
		logic out_free;    // result register can take a word this cycle
		logic skip;        // fetched open bracket on a zero cell
		logic scan_oob;    // scan address ran past the store
		logic scan_zero;   // scanned entry is a zero byte
		logic scan_match;  // scanned entry closes the loop
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bli_if.sv =====
// bli_if: valid/ready channels of the bracket language interpreter
// request channel carries commands, response channel carries one result per command
// no dependencies
`default_nettype none

interface bli_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] prog_addr;
	logic [7:0] prog_byte;
	logic       in_valid;
	logic [7:0] in_byte;

	modport source (output valid, command, prog_addr, prog_byte, in_valid, in_byte,
		input ready);
	modport sink (input valid, command, prog_addr, prog_byte, in_valid, in_byte,
		output ready);
endinterface

interface bli_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       out_valid;
	logic [7:0] out_byte;
	logic [7:0] prog_counter;

	modport source (output valid, status, out_valid, out_byte, prog_counter, input ready);
	modport sink (input valid, status, out_valid, out_byte, prog_counter, output ready);
endinterface

`default_nettype wire

// ===== rtl/bli_ram.sv =====
// bli_ram: generic single write port, single read port memory with registered read
// used for program store, data cells and loop stack
// no dependencies
`default_nettype none

module bli_ram #(
	parameter  int unsigned WIDTH = 8,
	parameter  int unsigned DEPTH = 256,
	localparam int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bli_ctrl.sv =====
// bli_ctrl: sequencing state machine of the interpreter
// depends on bli_pkg for states and the command/status structs
`default_nettype none

module bli_ctrl import bli_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.accept = 1'b1;
					state_d    = stat.req_exec ? S_EXEC : S_REPLY;
				end
			end
			S_REPLY: begin
				if (stat.out_free) begin
					ctl.reply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_EXEC: begin
				if (stat.skip) begin
					ctl.scan_start = 1'b1;
					state_d        = S_SCAN_RD;
				end else if (stat.out_free) begin
					ctl.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN_RD: begin
				if (stat.scan_oob) begin
					if (stat.out_free) begin
						ctl.scan_end = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					ctl.scan_rd = 1'b1;
					state_d     = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (stat.scan_zero || stat.scan_match) begin
					if (stat.out_free) begin
						ctl.scan_end = 1'b1;
						ctl.scan_hit = stat.scan_match;
						state_d      = S_IDLE;
					end
				end else begin
					ctl.scan_step = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q != S_IDLE)
		else $error("accepted word did not start processing");

	a_chk_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN_CHK |-> $past(state_q) == S_SCAN_RD || $past(state_q) == S_SCAN_CHK)
		else $error("scan check without a scan read");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> state_q == S_IDLE)
		else $error("request taken while busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/bli_dp.sv =====
// bli_dp: datapath of the interpreter: machine registers, memories, decode and result register
// depends on bli_pkg and bli_ram
`default_nettype none

module bli_dp import bli_pkg::*; #(
	parameter int unsigned PROG_DEPTH  = PROG_DEPTH_DEF,
	parameter int unsigned DATA_DEPTH  = DATA_DEPTH_DEF,
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ctl_cmd_t   ctl,
	output dp_stat_t        stat,
	input  wire logic [1:0] command,
	input  wire logic [7:0] prog_addr,
	input  wire logic [7:0] prog_byte,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output logic      [2:0] status,
	output logic            out_valid,
	output logic      [7:0] out_byte,
	output logic      [7:0] prog_counter
);

	localparam int unsigned PAW = $clog2(PROG_DEPTH);
	localparam int unsigned DAW = $clog2(DATA_DEPTH);
	localparam int unsigned SAW = $clog2(STACK_DEPTH);
	localparam int unsigned SDW = $clog2(STACK_DEPTH + 1);
	localparam logic [DAW-1:0] IDX_LAST = DAW'(DATA_DEPTH - 1);
	// cell index of data pointer 255, reached when the pointer wraps downward
	localparam logic [DAW-1:0] IDX_TOP  = DAW'(255 % DATA_DEPTH);

	// machine state
	logic [7:0]            pc_q;
	logic [7:0]            dp_q;
	logic [DAW-1:0]        idx_q;
	logic [SDW-1:0]        depth_q;
	status_t               halt_q;
	logic [DATA_DEPTH-1:0] dvld_q;
	logic                  dvalid_q;
	logic                  foob_q;
	logic [8:0]            scan_addr_q;
	logic [8:0]            level_q;

	// latched request word
	cmd_t       cmd_q;
	logic [7:0] paddr_q;
	logic [7:0] pbyte_q;
	logic       inv_q;
	logic [7:0] inb_q;

	// result register
	logic       rsp_vld_q;
	status_t    rst_q;
	logic       rov_q;
	logic [7:0] rob_q;
	logic [7:0] rpc_q;

	// memory ports
	logic [7:0]     prog_rd;
	logic [7:0]     data_rd;
	logic [7:0]     stack_rd;
	logic           prog_we;
	logic           prog_re;
	logic [PAW-1:0] prog_raddr;
	logic           data_we;
	logic           stack_we;
	logic [SDW-1:0] depth_m1;

	// decode
	logic [7:0]     instr;
	logic [7:0]     cur_cell;
	status_t        ex_status;
	logic [7:0]     ex_pc;
	logic [7:0]     ex_dp;
	logic [DAW-1:0] ex_idx;
	logic [SDW-1:0] ex_depth;
	logic           cell_we;
	logic [7:0]     cell_wd;
	logic           push;
	logic           ex_ov;
	logic [7:0]     ex_ob;

	// result word
	logic       emit;
	status_t    rsp_st_d;
	logic       rsp_ov_d;
	logic [7:0] rsp_ob_d;
	logic [7:0] rsp_pc_d;

	logic is_start;

	assign is_start   = cmd_q == CMD_START;
	assign instr      = foob_q ? CH_NUL : prog_rd;
	assign cur_cell   = dvalid_q ? data_rd : 8'h00;
	assign depth_m1   = depth_q - 1'b1;
	assign prog_we    = ctl.reply && cmd_q == CMD_LOAD && {1'b0, paddr_q} < 9'(PROG_DEPTH);
	assign prog_re    = ctl.accept || ctl.scan_rd;
	assign prog_raddr = ctl.scan_rd ? scan_addr_q[PAW-1:0] : pc_q[PAW-1:0];
	assign data_we    = ctl.exec && cell_we;
	assign stack_we   = ctl.exec && push;

	bli_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
		.clk   (clk),
		.we    (prog_we),
		.waddr (paddr_q[PAW-1:0]),
		.wdata (pbyte_q),
		.re    (prog_re),
		.raddr (prog_raddr),
		.rdata (prog_rd)
	);

	bli_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data (
		.clk   (clk),
		.we    (data_we),
		.waddr (idx_q),
		.wdata (cell_wd),
		.re    (ctl.accept),
		.raddr (idx_q),
		.rdata (data_rd)
	);

	bli_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stack_we),
		.waddr (depth_q[SAW-1:0]),
		.wdata (pc_q + 8'd1),
		.re    (ctl.accept),
		.raddr (depth_m1[SAW-1:0]),
		.rdata (stack_rd)
	);

	// one instruction, given the fetched character and cell
	always_comb begin
		ex_status = ST_OK;
		ex_pc     = pc_q + 8'd1;
		ex_dp     = dp_q;
		ex_idx    = idx_q;
		ex_depth  = depth_q;
		cell_we   = 1'b0;
		cell_wd   = cur_cell;
		push      = 1'b0;
		ex_ov     = 1'b0;
		ex_ob     = 8'h00;
		case (instr)
			CH_RIGHT: begin
				ex_dp  = dp_q + 8'd1;
				ex_idx = (dp_q == 8'hFF || idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			end
			CH_LEFT: begin
				ex_dp = dp_q - 8'd1;
				if (dp_q == 8'h00) begin
					ex_idx = IDX_TOP;
				end else if (idx_q == '0) begin
					ex_idx = IDX_LAST;
				end else begin
					ex_idx = idx_q - 1'b1;
				end
			end
			CH_INC: begin
				cell_we = 1'b1;
				cell_wd = cur_cell + 8'd1;
			end
			CH_DEC: begin
				cell_we = 1'b1;
				cell_wd = cur_cell - 8'd1;
			end
			CH_OUT: begin
				ex_ov = 1'b1;
				ex_ob = cur_cell;
			end
			CH_IN: begin
				if (!inv_q) begin
					ex_status = ST_WAIT;
				end else begin
					cell_we = 1'b1;
					cell_wd = inb_q;
				end
			end
			CH_OPEN: begin
				if (depth_q == SDW'(STACK_DEPTH)) begin
					ex_status = ST_OVER;
				end else begin
					push     = 1'b1;
					ex_depth = depth_q + 1'b1;
				end
			end
			CH_CLOSE: begin
				if (depth_q == '0) begin
					ex_status = ST_UNDER;
				end else if (cur_cell == 8'h00) begin
					ex_depth = depth_m1;
				end else begin
					ex_pc = stack_rd;
				end
			end
			CH_NUL: begin
				ex_status = ST_END;
			end
			default: begin
				ex_status = ST_INVALID;
			end
		endcase
	end

	always_comb begin
		stat.req_exec   = cmd_t'(command) == CMD_EXEC && halt_q == ST_OK;
		stat.out_free   = !rsp_vld_q || rsp_ready;
		stat.skip       = instr == CH_OPEN && cur_cell == 8'h00;
		stat.scan_oob   = scan_addr_q >= 9'(PROG_DEPTH);
		stat.scan_zero  = prog_rd == CH_NUL;
		stat.scan_match = prog_rd == CH_CLOSE && level_q == 9'd1;
	end

	assign emit = ctl.reply || ctl.exec || ctl.scan_end;

	always_comb begin
		rsp_st_d = halt_q;
		rsp_ov_d = 1'b0;
		rsp_ob_d = 8'h00;
		rsp_pc_d = pc_q;
		if (ctl.reply) begin
			if (is_start) begin
				rsp_st_d = ST_OK;
				rsp_pc_d = 8'h00;
			end
		end else if (ctl.exec) begin
			rsp_st_d = ex_status;
			rsp_ov_d = ex_ov;
			rsp_ob_d = ex_ob;
			if (ex_status == ST_OK) begin
				rsp_pc_d = ex_pc;
			end
		end else if (ctl.scan_hit) begin
			rsp_st_d = ST_OK;
			rsp_pc_d = scan_addr_q[7:0] + 8'd1;
		end else begin
			rsp_st_d = ST_UNMATCHED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			dp_q        <= '0;
			idx_q       <= '0;
			depth_q     <= '0;
			halt_q      <= ST_OK;
			dvld_q      <= '0;
			scan_addr_q <= '0;
			level_q     <= '0;
			rsp_vld_q   <= 1'b0;
		end else begin
			if (ctl.reply && is_start) begin
				pc_q    <= '0;
				dp_q    <= '0;
				idx_q   <= '0;
				depth_q <= '0;
				halt_q  <= ST_OK;
				dvld_q  <= '0;
			end
			if (ctl.exec) begin
				if (ex_status == ST_OK) begin
					pc_q    <= ex_pc;
					dp_q    <= ex_dp;
					idx_q   <= ex_idx;
					depth_q <= ex_depth;
				end else if (ex_status != ST_WAIT) begin
					halt_q <= ex_status;
				end
			end
			if (data_we) begin
				dvld_q[idx_q] <= 1'b1;
			end
			if (ctl.scan_start) begin
				scan_addr_q <= {1'b0, pc_q} + 9'd1;
				level_q     <= 9'd1;
			end
			if (ctl.scan_step) begin
				scan_addr_q <= scan_addr_q + 9'd1;
				if (prog_rd == CH_OPEN) begin
					level_q <= level_q + 9'd1;
				end else if (prog_rd == CH_CLOSE) begin
					level_q <= level_q - 9'd1;
				end
			end
			if (ctl.scan_end) begin
				if (ctl.scan_hit) begin
					pc_q <= scan_addr_q[7:0] + 8'd1;
				end else begin
					halt_q <= ST_UNMATCHED;
				end
			end
			if (emit) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q    <= cmd_t'(command);
			paddr_q  <= prog_addr;
			pbyte_q  <= prog_byte;
			inv_q    <= in_valid;
			inb_q    <= in_byte;
			foob_q   <= {1'b0, pc_q} >= 9'(PROG_DEPTH);
			dvalid_q <= dvld_q[idx_q];
		end
		if (emit) begin
			rst_q <= rsp_st_d;
			rov_q <= rsp_ov_d;
			rob_q <= rsp_ob_d;
			rpc_q <= rsp_pc_d;
		end
	end

	assign rsp_valid    = rsp_vld_q;
	assign status       = rst_q;
	assign out_valid    = rov_q;
	assign out_byte     = rob_q;
	assign prog_counter = rpc_q;

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= SDW'(STACK_DEPTH))
		else $error("loop stack depth beyond capacity");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, idx_q} < (DAW + 1)'(DATA_DEPTH))
		else $error("cell index outside data store");

	a_wait_not_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q != ST_WAIT)
		else $error("waiting status latched as halt");
`endif

endmodule

`default_nettype wire

// ===== rtl/bracket_language_interpreter.sv =====
// bracket_language_interpreter: top level of the eight-instruction tape machine
// depends on bli_pkg, bli_if, bli_ctrl, bli_dp, bli_ram
//
//   channel | role   | word
//   --------+--------+------------------------------------------------------
//   req     | sink   | command, prog_addr, prog_byte, in_valid, in_byte
//   rsp     | source | status, out_valid, out_byte, prog_counter
//
// load, start, none and steps on a halted machine are accepted, then finished with a reply
// an instruction is accepted with program, cell and stack reads, then executed
// an open bracket on a zero cell scans the program store forward, reading then checking each entry,
// until the matching close, a zero byte or the end of the store
// a result waiting on rsp holds the block in its last cycle; req is taken only when idle
// reset clears the machine registers, the result valid flag and the data cell valid bits; no clearing pass is needed
`default_nettype none

module bracket_language_interpreter import bli_pkg::*; #(
	parameter int unsigned PROG_DEPTH  = PROG_DEPTH_DEF,
	parameter int unsigned DATA_DEPTH  = DATA_DEPTH_DEF,
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bli_in_if.sink   req,
	bli_out_if.source rsp
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	bli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	bli_dp #(
		.PROG_DEPTH  (PROG_DEPTH),
		.DATA_DEPTH  (DATA_DEPTH),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.command      (req.command),
		.prog_addr    (req.prog_addr),
		.prog_byte    (req.prog_byte),
		.in_valid     (req.in_valid),
		.in_byte      (req.in_byte),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.status       (rsp.status),
		.out_valid    (rsp.out_valid),
		.out_byte     (rsp.out_byte),
		.prog_counter (rsp.prog_counter)
	);

endmodule

`default_nettype wire
